@@ src/srrf_pkg.sv @@
// Shared types and constants for the sorted run repeat filter.
// No dependencies; imported by the top level.
package srrf_pkg;

  localparam int unsigned RUN_DEPTH  = 31;
  localparam int unsigned IDX_W      = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int unsigned LEN_W      = 6;
  localparam int unsigned KMER_W     = 64;
  localparam int unsigned NODE_W     = 32;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned ENTRY_W    = NODE_W + OFFSET_W;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [LEN_W-1:0]   LIMIT_RESET = LEN_W'(16);
  localparam logic [LEN_W-1:0]   LIMIT_MAX   = LEN_W'(RUN_DEPTH + 1);
  localparam logic [LEN_W-1:0]   DEPTH_LEN   = LEN_W'(RUN_DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  // register index taken from paddr[2]
  localparam logic REG_REPEAT_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_ADD,
    S_END,
    S_RD,
    S_LD,
    S_SUM
  } state_e;

endpackage

@@ src/srrf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srrf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 31,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sorted_run_repeat_filter_core.sv @@
// Top level of the sorted run repeat filter: control, run state and output register.
// Depends on srrf_pkg and srrf_ram (run buffer of node and offset words).
//
// Usage:
//   Input words (kmer, node, offset, end flag) arrive sorted by k-mer on a
//   valid/stall channel. Records with equal k-mer form a run held in the run
//   buffer RAM. When the k-mer changes or the stream ends, a run shorter than
//   repeat_limit is sent out in arrival order; a longer run is dropped. The
//   word that ends the stream is followed by a summary word with the kept count.
//   A record that emits nothing goes through check, buffer write and return to
//   idle before the next word is taken; each emitted record adds a run buffer
//   read and an output load, since the run buffer RAM has registered read data,
//   and a word that ends the stream adds an end check and the summary.
//   One word is processed at a time.
//   The output register holds a result until the receiver drops stall; the
//   sequencer waits on a full output register, and input stall stays high
//   while a word is in work.
//   Reset clears the run state, kept count and output valid, and sets
//   repeat_limit to 16. repeat_limit is written over the APB port at address 0.
module sorted_run_repeat_filter_core
  import srrf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [KMER_W-1:0]     kmer_value_i,
  input  logic [NODE_W-1:0]     node_id_i,
  input  logic signed [OFFSET_W-1:0] signed_offset_i,
  input  logic                  stream_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [KMER_W-1:0]     out_kmer_o,
  output logic [NODE_W-1:0]     out_node_o,
  output logic signed [OFFSET_W-1:0] out_offset_o,
  output logic                  is_summary_o,
  output logic [COUNT_W-1:0]    kept_count_o,
  output logic                  last_of_run_o
);

  state_e state_q, state_d;

  logic [LEN_W-1:0]    limit_q;
  logic [KMER_W-1:0]   key_q, key_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic                open_q, open_d;
  logic [COUNT_W-1:0]  kept_q, kept_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                phase_end_q, phase_end_d;

  logic [KMER_W-1:0]   in_kmer_q;
  logic [NODE_W-1:0]   in_node_q;
  logic [OFFSET_W-1:0] in_offset_q;
  logic                in_end_q;

  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [KMER_W-1:0]   out_kmer_q, out_kmer_d;
  logic [NODE_W-1:0]   out_node_q, out_node_d;
  logic [OFFSET_W-1:0] out_offset_q, out_offset_d;
  logic                out_sum_q, out_sum_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;
  logic                out_last_q, out_last_d;

  logic                ram_we, ram_re;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [LEN_W-1:0]    lim;
  logic                in_accept, cfg_write, out_free, new_run, idx_last;
  logic [COUNT_W-1:0]  kept_inc;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_REPEAT_LIMIT) ?
                     APB_DATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_write && paddr[2] == REG_REPEAT_LIMIT) begin
      limit_q <= pwdata[LEN_W-1:0];
    end
  end

  assign lim        = (limit_q > LIMIT_MAX) ? LIMIT_MAX : limit_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign new_run    = !(open_q && in_kmer_q == key_q);
  assign idx_last   = (LEN_W'(idx_q) == len_q - LEN_W'(1));
  assign kept_inc   = (kept_q != COUNT_MAX) ? kept_q + COUNT_W'(1) : kept_q;

  assign ram_we = (state_q == S_ADD) && (len_q < lim) && (len_q < DEPTH_LEN);
  assign ram_re = (state_q == S_RD);

  srrf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RUN_DEPTH)
  ) u_run_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q[IDX_W-1:0]),
    .wdata_i ({in_node_q, in_offset_q}),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    len_d        = len_q;
    open_d       = open_q;
    kept_d       = kept_q;
    idx_d        = idx_q;
    phase_end_d  = phase_end_q;
    out_load     = 1'b0;
    out_kmer_d   = key_q;
    out_node_d   = ram_rdata[ENTRY_W-1:OFFSET_W];
    out_offset_d = ram_rdata[OFFSET_W-1:0];
    out_sum_d    = 1'b0;
    out_count_d  = kept_q;
    out_last_d   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (!new_run) begin
          state_d = S_ADD;
        end else if (open_q && len_q < lim && len_q != '0) begin
          kept_d      = kept_inc;
          idx_d       = '0;
          phase_end_d = 1'b0;
          state_d     = S_RD;
        end else begin
          if (open_q && len_q < lim) begin
            kept_d = kept_inc;
          end
          key_d   = in_kmer_q;
          len_d   = '0;
          open_d  = 1'b1;
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (len_q < lim) begin
          len_d = len_q + LEN_W'(1);
        end
        state_d = in_end_q ? S_END : S_IDLE;
      end
      S_END: begin
        if (len_q < lim) begin
          kept_d      = kept_inc;
          idx_d       = '0;
          phase_end_d = 1'b1;
          state_d     = S_RD;
        end else begin
          state_d = S_SUM;
        end
      end
      S_RD: begin
        state_d = S_LD;
      end
      S_LD: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = idx_last && !phase_end_q && !in_end_q;
          if (idx_last) begin
            if (phase_end_q) begin
              state_d = S_SUM;
            end else begin
              key_d   = in_kmer_q;
              len_d   = '0;
              open_d  = 1'b1;
              state_d = S_ADD;
            end
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_RD;
          end
        end
      end
      S_SUM: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kmer_d   = '0;
          out_node_d   = '0;
          out_offset_d = '0;
          out_sum_d    = 1'b1;
          out_last_d   = 1'b1;
          kept_d       = '0;
          len_d        = '0;
          key_d        = '0;
          open_d       = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_q       <= '0;
      len_q       <= '0;
      open_q      <= 1'b0;
      kept_q      <= '0;
      idx_q       <= '0;
      phase_end_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_q       <= key_d;
      len_q       <= len_d;
      open_q      <= open_d;
      kept_q      <= kept_d;
      idx_q       <= idx_d;
      phase_end_q <= phase_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_kmer_q   <= kmer_value_i;
      in_node_q   <= node_id_i;
      in_offset_q <= signed_offset_i;
      in_end_q    <= stream_end_i;
    end
    if (out_load) begin
      out_kmer_q   <= out_kmer_d;
      out_node_q   <= out_node_d;
      out_offset_q <= out_offset_d;
      out_sum_q    <= out_sum_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kmer_o    = out_kmer_q;
  assign out_node_o    = out_node_q;
  assign out_offset_o  = out_offset_q;
  assign is_summary_o  = out_sum_q;
  assign kept_count_o  = out_count_q;
  assign last_of_run_o = out_last_q;

endmodule
